// ===== hdl/cpbc_pkg.sv =====
// Shared types, codes and a helper function for the CIGAR pileup base counter.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package cpbc_pkg;

  localparam int REF_LEN_DEF    = 32768;
  localparam int COUNT_BITS_DEF = 32;
  localparam int NUM_LANES      = 8;
  localparam int OUT_BITS       = 32;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_CIGAR   = 2'd1,
    KIND_BASE    = 2'd2,
    KIND_READOUT = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    OP_M    = 4'd0,
    OP_I    = 4'd1,
    OP_D    = 4'd2,
    OP_N    = 4'd3,
    OP_S    = 4'd4,
    OP_H    = 4'd5,
    OP_P    = 4'd6,
    OP_EQ   = 4'd7,
    OP_X    = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    LANE_A = 2'd0,
    LANE_T = 2'd1,
    LANE_C = 2'd2,
    LANE_G = 2'd3
  } lane_e;

  localparam logic [7:0] CHAR_A_UC = 8'h41;
  localparam logic [7:0] CHAR_T_UC = 8'h54;
  localparam logic [7:0] CHAR_C_UC = 8'h43;
  localparam logic [7:0] CHAR_G_UC = 8'h47;
  localparam logic [7:0] CHAR_A_LC = 8'h61;
  localparam logic [7:0] CHAR_T_LC = 8'h74;
  localparam logic [7:0] CHAR_C_LC = 8'h63;
  localparam logic [7:0] CHAR_G_LC = 8'h67;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_UPDATE = 2'd2,
    ST_RESULT = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic clear_en;
    logic take;
    logic rmw_write;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_rmw;
    logic is_readout;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic  hit;
    lane_e lane;
  } lane_t;

  function automatic lane_t decode_base(logic [7:0] c);
    lane_t r;
    r.hit  = 1'b1;
    r.lane = LANE_A;
    unique case (c)
      CHAR_A_UC, CHAR_A_LC: r.lane = LANE_A;
      CHAR_T_UC, CHAR_T_LC: r.lane = LANE_T;
      CHAR_C_UC, CHAR_C_LC: r.lane = LANE_C;
      CHAR_G_UC, CHAR_G_LC: r.lane = LANE_G;
      default:              r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/cpbc_if.sv =====
// Valid/ready channel interfaces for input items and readout results.
// Depends on cpbc_pkg for field widths.
interface cpbc_in_if import cpbc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [14:0] position;
  logic        mate_elsewhere;
  logic        secondary;
  logic [3:0]  op_code;
  logic [15:0] op_length;
  logic [7:0]  read_char;

  modport source (output valid, kind, position, mate_elsewhere, secondary, op_code,
                  op_length, read_char, input ready);
  modport sink   (input valid, kind, position, mate_elsewhere, secondary, op_code,
                  op_length, read_char, output ready);
endinterface

interface cpbc_out_if import cpbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] same_a;
  logic [OUT_BITS-1:0] same_t;
  logic [OUT_BITS-1:0] same_c;
  logic [OUT_BITS-1:0] same_g;
  logic [OUT_BITS-1:0] away_a;
  logic [OUT_BITS-1:0] away_t;
  logic [OUT_BITS-1:0] away_c;
  logic [OUT_BITS-1:0] away_g;

  modport source (output valid, same_a, same_t, same_c, same_g, away_a, away_t, away_c,
                  away_g, input ready);
  modport sink   (input valid, same_a, same_t, same_c, same_g, away_a, away_t, away_c,
                  away_g, output ready);
endinterface

// ===== hdl/cigar_pileup_base_counter.sv =====
// Top level of the CIGAR pileup base counter: controller, datapath and checks.
// Depends on cpbc_pkg, cpbc_if, cpbc_ctrl and cpbc_datapath.
//
//   Channel  Dir  Handshake      Payload
//   in_i     in   valid/ready    kind, position, mate_elsewhere, secondary, op_code,
//                                op_length, read_char
//   out_o    out  valid/ready    same_a/t/c/g, away_a/t/c/g (32 bits each)
//
// Read starts, CIGAR operations and bases that are not counted leave the controller in ST_IDLE.
// A counted base reads its row of the count memory when taken and writes it back in
// ST_UPDATE, as the memory has a single read and a single write port; a readout reads
// its row, then waits in ST_RESULT for the output register to empty.
// After reset a clearing pass zeroes every row of the memory; in_i is not ready.
// A stalled result sits in the output register; the next transfer on in_i is still
// taken, and only a second readout waits for it.
module cigar_pileup_base_counter import cpbc_pkg::*; #(
  parameter int REF_LEN    = REF_LEN_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpbc_in_if.sink    in_i,
  cpbc_out_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cpbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cpbc_datapath #(
    .REF_LEN    (REF_LEN),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .kind_i           (in_i.kind),
    .position_i       (in_i.position),
    .mate_elsewhere_i (in_i.mate_elsewhere),
    .secondary_i      (in_i.secondary),
    .op_code_i        (in_i.op_code),
    .op_length_i      (in_i.op_length),
    .read_char_i      (in_i.read_char),
    .out_o            (out_o)
  );

  // A row write-back always follows the transfer of the base that read it.
  a_rmw_follows_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rmw_write |-> $past(cmd.take))
    else $error("count write-back without a preceding base transfer");

  // A new result never overwrites one that is still waiting.
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result loaded over a pending result");

  // No input transfer is taken while the clearing pass runs.
  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_en |-> !in_i.ready)
    else $error("input ready during the clearing pass");

endmodule

// ===== hdl/cpbc_ctrl.sv =====
// Controller state machine: clearing pass, item intake, count update and result load.
// Depends on cpbc_pkg for the state enum and the command and status structs.
module cpbc_ctrl import cpbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.is_readout) begin
            state_d = ST_RESULT;
          end else if (status_i.need_rmw) begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      ST_RESULT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.clear_en  = (state_q == ST_CLEAR);
    cmd_o.take      = in_valid_i && (state_q == ST_IDLE);
    cmd_o.rmw_write = (state_q == ST_UPDATE);
    cmd_o.out_load  = (state_q == ST_RESULT) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/cpbc_datapath.sv =====
// Datapath: read walk registers, count memory with read-modify-write, output register.
// Depends on cpbc_pkg and the cpbc_out_if channel interface.
module cpbc_datapath import cpbc_pkg::*; #(
  parameter int REF_LEN    = REF_LEN_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  logic [1:0]  kind_i,
  input  logic [14:0] position_i,
  input  logic        mate_elsewhere_i,
  input  logic        secondary_i,
  input  logic [3:0]  op_code_i,
  input  logic [15:0] op_length_i,
  input  logic [7:0]  read_char_i,
  cpbc_out_if.source  out_o
);

  localparam int AW    = $clog2(REF_LEN);
  localparam int ROW_W = NUM_LANES * COUNT_BITS;

  logic [15:0]      ptr_q, ptr_d;
  logic [15:0]      rem_q, rem_d;
  logic [3:0]       mode_q, mode_d;
  logic             bank_q, bank_d;
  logic             ignored_q, ignored_d;

  logic [AW-1:0]    clear_cnt_q;
  logic [AW-1:0]    wr_addr_q;
  logic [2:0]       slot_q;
  logic             oob_q;
  logic [ROW_W-1:0] rd_q;
  logic [ROW_W-1:0] count_mem [REF_LEN];

  logic [16:0]      pos_ext;
  logic             pos_in_range;
  logic             ptr_in_range;
  lane_t            lane;
  logic             base_live;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [ROW_W-1:0] row_upd;
  logic [COUNT_BITS-1:0] cur_cnt;

  logic             out_valid_q;
  logic [OUT_BITS-1:0] out_q [NUM_LANES];

  assign pos_ext      = {2'b00, position_i};
  assign pos_in_range = pos_ext < 17'(REF_LEN);
  assign ptr_in_range = {1'b0, ptr_q} < 17'(REF_LEN);
  assign lane         = decode_base(read_char_i);
  assign base_live    = (kind_i == KIND_BASE) && !ignored_q && (rem_q != 16'd0);

  assign status_o.clear_last = (clear_cnt_q == AW'(REF_LEN - 1));
  assign status_o.need_rmw   = base_live && (mode_q == OP_M) && lane.hit && ptr_in_range;
  assign status_o.is_readout = (kind_i == KIND_READOUT);
  assign status_o.out_free   = !out_valid_q || out_o.ready;

  // Walk state is worked out from each transfer and registered at the transfer's clock edge.
  always_comb begin
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    mode_d    = mode_q;
    bank_d    = bank_q;
    ignored_d = ignored_q;
    if (cmd_i.take) begin
      unique case (kind_i)
        KIND_START: begin
          ptr_d     = {1'b0, position_i};
          bank_d    = mate_elsewhere_i;
          ignored_d = secondary_i;
          rem_d     = 16'd0;
          mode_d    = OP_M;
        end
        KIND_CIGAR: begin
          if (!ignored_q) begin
            mode_d = op_code_i;
            unique case (op_code_i)
              OP_M, OP_I, OP_S: rem_d = op_length_i;
              OP_EQ, OP_X: begin
                rem_d = op_length_i;
                ptr_d = ptr_q + op_length_i;
              end
              OP_D, OP_N: begin
                rem_d = 16'd0;
                ptr_d = ptr_q + op_length_i;
              end
              default: rem_d = 16'd0;
            endcase
          end
        end
        KIND_BASE: begin
          if (base_live) begin
            rem_d = rem_q - 16'd1;
            if (mode_q == OP_M) ptr_d = ptr_q + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_cnt = rd_q[slot_q * COUNT_BITS +: COUNT_BITS];
    row_upd = rd_q;
    if (cur_cnt != {COUNT_BITS{1'b1}}) begin
      row_upd[slot_q * COUNT_BITS +: COUNT_BITS] = cur_cnt + COUNT_BITS'(1);
    end
  end

  assign mem_re    = cmd_i.take && (status_o.need_rmw || (status_o.is_readout && pos_in_range));
  assign mem_raddr = status_o.is_readout ? pos_ext[AW-1:0] : ptr_q[AW-1:0];
  assign mem_we    = cmd_i.clear_en || cmd_i.rmw_write;
  assign mem_waddr = cmd_i.clear_en ? clear_cnt_q : wr_addr_q;
  assign mem_wdata = cmd_i.clear_en ? '0 : row_upd;

  always_ff @(posedge clk_i) begin
    if (mem_we) count_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= count_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      wr_addr_q <= ptr_q[AW-1:0];
      slot_q    <= {bank_q, lane.lane};
      oob_q     <= !pos_in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      rem_q       <= '0;
      mode_q      <= OP_M;
      bank_q      <= 1'b0;
      ignored_q   <= 1'b1;
      clear_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      rem_q     <= rem_d;
      mode_q    <= mode_d;
      bank_q    <= bank_d;
      ignored_q <= ignored_d;
      if (cmd_i.clear_en) clear_cnt_q <= clear_cnt_q + AW'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (cmd_i.out_load) begin
        out_q[k] <= oob_q ? '0 : OUT_BITS'(rd_q[k * COUNT_BITS +: COUNT_BITS]);
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.same_a = out_q[0];
  assign out_o.same_t = out_q[1];
  assign out_o.same_c = out_q[2];
  assign out_o.same_g = out_q[3];
  assign out_o.away_a = out_q[4];
  assign out_o.away_t = out_q[5];
  assign out_o.away_c = out_q[6];
  assign out_o.away_g = out_q[7];

endmodule
